// ===== src/rcdt_pkg.sv =====
// Shared types and constants for the reference-counted deduplicating table.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package rcdt_pkg;

  // First key word that marks a reserved key
  localparam logic [31:0] RESERVED_FIRST = 32'h0101_0100;

  // Configuration register: reset value and register index (paddr[2])
  localparam logic [4:0] ENTRIES_RESET      = 5'd10;
  localparam logic       REG_ENTRIES_IN_USE = 1'b0;

  // Result status codes
  typedef enum logic [2:0] {
    ST_MATCHED   = 3'd0,
    ST_ALLOCATED = 3'd1,
    ST_FULL      = 3'd2,
    ST_RESERVED  = 3'd3,
    ST_RELEASE   = 3'd4
  } status_t;

  // Table write operations
  typedef enum logic [1:0] {
    WR_NONE,
    WR_ALLOC,
    WR_INC,
    WR_DEC
  } wr_op_t;

  // Source of the result slot number
  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_FREE,
    SLOT_SCAN
  } slot_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      load;      // capture the input transaction, restart the scan
    logic      rd_rel;    // read the entry named by the release index
    logic      step;      // advance the scan, note the first free slot
    wr_op_t    wr_op;     // table update
    logic      emit;      // load the result register
    status_t   code;      // result status
    slot_sel_t slot_sel;  // result slot source
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic reserved;   // key on the input ports is reserved
    logic scan_end;   // scan counter reached the active slot count
    logic hit;        // scanned entry is live and its key matches
    logic have_free;  // a free slot was seen during the scan
    logic rel_ok;     // release index in range and its entry live
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/rcdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rcdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write when enabled, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/rcdt_ctrl.sv =====
// Sequencer for the table: accepts transactions, walks the slots and
// issues table updates and results. Depends on rcdt_pkg.
`default_nettype none

module rcdt_ctrl
  import rcdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_mode,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    REL_CHK,
    ACQ_RD,
    ACQ_CHK
  } state_t;

  state_t state_r, state_nxt;

  // Decode state and status into commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_mode) begin
            cmd.rd_rel = 1'b1;
            state_nxt  = REL_CHK;
          end else if (stat.reserved) begin
            cmd.emit     = 1'b1;
            cmd.code     = ST_RESERVED;
            cmd.slot_sel = SLOT_ZERO;
          end else begin
            state_nxt = ACQ_RD;
          end
        end
      end
      REL_CHK: begin
        if (stat.rel_ok) begin
          cmd.wr_op = WR_DEC;
        end
        cmd.emit     = 1'b1;
        cmd.code     = ST_RELEASE;
        cmd.slot_sel = SLOT_ZERO;
        state_nxt    = IDLE;
      end
      ACQ_RD: begin
        if (stat.scan_end) begin
          cmd.emit = 1'b1;
          if (stat.have_free) begin
            cmd.wr_op    = WR_ALLOC;
            cmd.code     = ST_ALLOCATED;
            cmd.slot_sel = SLOT_FREE;
          end else begin
            cmd.code     = ST_FULL;
            cmd.slot_sel = SLOT_ZERO;
          end
          state_nxt = IDLE;
        end else begin
          state_nxt = ACQ_CHK;
        end
      end
      ACQ_CHK: begin
        if (stat.hit) begin
          cmd.wr_op    = WR_INC;
          cmd.emit     = 1'b1;
          cmd.code     = ST_MATCHED;
          cmd.slot_sel = SLOT_SCAN;
          state_nxt    = IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ACQ_RD;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != IDLE);

  // A slot check always follows the read issued for it
  a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ACQ_CHK |-> $past(state_r) == ACQ_RD)
    else $error("slot check without a preceding read");

  // Every table update ends a transaction with a result
  a_wr_with_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_op != WR_NONE |-> cmd.emit)
    else $error("table update without a result");

  // After a result the sequencer is free again
  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == IDLE)
    else $error("sequencer still busy after a result");

endmodule

`default_nettype wire

// ===== src/rcdt_dp.sv =====
// Datapath for the table: key and count RAMs, valid bits, scan counter,
// free-slot capture and the result register. Depends on rcdt_pkg, rcdt_ram.
`default_nettype none

module rcdt_dp
  import rcdt_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [4:0]        entries,
  input  logic [31:0]       key_first,
  input  logic [31:0]       key_second,
  input  logic [31:0]       key_third,
  input  logic signed [4:0] slot_index,
  output logic              res_valid,
  output logic [3:0]        res_slot,
  output logic [2:0]        res_status
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W = 96;

  // Captured transaction
  logic [31:0]       key_first_r, key_second_r, key_third_r;
  logic [31:0]       key_first_nxt, key_second_nxt, key_third_nxt;
  logic [4:0]        idx_raw_r, idx_raw_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // Scan state
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  free_r, free_nxt;
  logic              have_free_r, have_free_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic              valid_rd_r, valid_rd_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_slot_r, out_slot_nxt;
  status_t           out_status_r, out_status_nxt;

  // RAM ports
  logic [IDX_W-1:0]      raddr, waddr;
  logic                  cnt_we, key_we;
  logic [COUNT_BITS-1:0] cnt_rd, cnt_wd;
  logic [KEY_W-1:0]      key_rd;

  logic [CW-1:0]    n_act;
  logic [IDX_W-1:0] scan_idx;
  logic             live;

  // Clamp the active slot count to the table size
  assign n_act    = (32'(entries) >= MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(entries);
  assign scan_idx = cnt_r[IDX_W-1:0];
  assign raddr    = cmd.rd_rel ? IDX_W'(slot_index[3:0]) : scan_idx;

  // Evaluate the entry read in the previous cycle
  assign live = valid_rd_r && (cnt_rd != '0);

  assign stat.reserved  = (key_first == RESERVED_FIRST);
  assign stat.scan_end  = (cnt_r >= n_act);
  assign stat.hit       = live && (key_rd == {key_first_r, key_second_r, key_third_r});
  assign stat.have_free = have_free_r;
  assign stat.rel_ok    = !idx_raw_r[4] && (32'(idx_raw_r[3:0]) < 32'(n_act)) && live;

  // Select write address and count value
  always_comb begin
    waddr  = scan_idx;
    cnt_wd = cnt_rd;
    cnt_we = 1'b0;
    key_we = 1'b0;
    case (cmd.wr_op)
      WR_ALLOC: begin
        waddr  = free_r;
        cnt_wd = COUNT_BITS'(1);
        cnt_we = 1'b1;
        key_we = 1'b1;
      end
      WR_INC: begin
        waddr  = scan_idx;
        cnt_wd = (&cnt_rd) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
        cnt_we = 1'b1;
      end
      WR_DEC: begin
        waddr  = idx_r;
        cnt_wd = cnt_rd - COUNT_BITS'(1);
        cnt_we = 1'b1;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  // Next values of the datapath registers
  always_comb begin
    key_first_nxt  = key_first_r;
    key_second_nxt = key_second_r;
    key_third_nxt  = key_third_r;
    idx_raw_nxt    = idx_raw_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    free_nxt       = free_r;
    have_free_nxt  = have_free_r;
    valid_nxt      = valid_r;
    valid_rd_nxt   = valid_r[raddr];
    out_valid_nxt  = cmd.emit;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;

    // capture the transaction and restart the scan
    if (cmd.load) begin
      key_first_nxt  = key_first;
      key_second_nxt = key_second;
      key_third_nxt  = key_third;
      idx_raw_nxt    = slot_index;
      idx_nxt        = IDX_W'(slot_index[3:0]);
      cnt_nxt        = '0;
      have_free_nxt  = 1'b0;
    end

    // advance the scan, keep the lowest free slot
    if (cmd.step) begin
      cnt_nxt = cnt_r + CW'(1);
      if (!live && !have_free_r) begin
        free_nxt      = scan_idx;
        have_free_nxt = 1'b1;
      end
    end

    if (cmd.wr_op == WR_ALLOC) begin
      valid_nxt[free_r] = 1'b1;
    end

    // load the result
    if (cmd.emit) begin
      out_status_nxt = cmd.code;
      case (cmd.slot_sel)
        SLOT_FREE: out_slot_nxt = 4'(free_r);
        SLOT_SCAN: out_slot_nxt = 4'(scan_idx);
        default:   out_slot_nxt = 4'd0;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      have_free_r <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      have_free_r <= have_free_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_first_r  <= key_first_nxt;
    key_second_r <= key_second_nxt;
    key_third_r  <= key_third_nxt;
    idx_raw_r    <= idx_raw_nxt;
    idx_r        <= idx_nxt;
    free_r       <= free_nxt;
    valid_rd_r   <= valid_rd_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  // Reference counts
  rcdt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wd),
    .raddr (raddr),
    .rdata (cnt_rd)
  );

  // Stored keys
  rcdt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata ({key_first_r, key_second_r, key_third_r}),
    .raddr (raddr),
    .rdata (key_rd)
  );

  assign res_valid  = out_valid_r;
  assign res_slot   = out_slot_r;
  assign res_status = out_status_r;

  // Allocation only into a slot found free during the scan
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_op == WR_ALLOC |-> have_free_r)
    else $error("allocation without a free slot");

  // A decrement only hits a live entry
  a_dec_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_op == WR_DEC |-> valid_rd_r && cnt_rd != '0)
    else $error("decrement of a free slot");

  // Results other than matched or allocated carry slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_MATCHED && out_status_r != ST_ALLOCATED
      |-> out_slot_r == 4'd0)
    else $error("nonzero slot on a result without a slot");

endmodule

`default_nettype wire

// ===== src/refcounted_dedup_table_top.sv =====
// Top level of the reference-counted deduplicating table: register port,
// sequencer and datapath. Depends on rcdt_pkg, rcdt_ctrl, rcdt_dp.
//
//   channel   direction  handshake                 payload
//   -------   ---------  ------------------------  --------------------------------
//   config    in/out     psel, penable, pready     paddr, pwrite, pwdata, prdata
//   command   in         start, busy               in_mode, in_key_*, in_slot_index
//   result    out        out_valid (one cycle)     out_slot_out, out_status
//
// A transaction is taken when start is high and busy is low; its result
// strobes in the cycle after the last busy cycle. A reserved key is answered
// without going busy, a release after its REL_CHK state. An acquire scans the
// active slots in order through the single read port of the entry RAMs, with a
// read and a check state per slot, up to a match, an allocation or a full table.
// Reset is synchronous and clears all counts through per-slot valid bits.
// The receiver cannot stall; a new transaction may start while a result shows.
`default_nettype none

module refcounted_dedup_table_top
  import rcdt_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic              in_mode,
  input  logic [31:0]       in_key_first,
  input  logic [31:0]       in_key_second,
  input  logic [31:0]       in_key_third,
  input  logic signed [4:0] in_slot_index,
  // result channel
  output logic              out_valid,
  output logic [3:0]        out_slot_out,
  output logic [2:0]        out_status
);

  logic [4:0] entries_r, entries_nxt;
  logic       cfg_wr;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  // Register write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    entries_nxt = entries_r;
    if (cfg_wr && paddr[2] == REG_ENTRIES_IN_USE) begin
      entries_nxt = pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ENTRIES_RESET;
    end else begin
      entries_r <= entries_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? {27'd0, entries_r} : 32'd0;

  rcdt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .busy    (busy),
    .stat    (stat),
    .cmd     (cmd)
  );

  rcdt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .entries    (entries_r),
    .key_first  (in_key_first),
    .key_second (in_key_second),
    .key_third  (in_key_third),
    .slot_index (in_slot_index),
    .res_valid  (out_valid),
    .res_slot   (out_slot_out),
    .res_status (out_status)
  );

endmodule

`default_nettype wire

// ===== bench/refcounted_dedup_table_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_dedup_table_top: directed and random
// acquire/release traffic, checked against a behavioral table model kept here.
// Depends on rcdt_pkg and the refcounted_dedup_table_top RTL.

module refcounted_dedup_table_top_tb;
  import rcdt_pkg::*;

  localparam int          SLOTS           = 16;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [2:0]  ENTRIES_ADDR    = {REG_ENTRIES_IN_USE, 2'b00};
  localparam int          LATENCY_CYCLES  = 2 * SLOTS + 4;
  localparam int          CYCLE_LIMIT     = 200_000;
  localparam int          REPEAT_ACQUIRES = 20;
  localparam int          POOL_SIZE       = 12;

  typedef struct packed {
    logic [3:0] slot;
    status_t    status;
  } table_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [31:0]       in_key_first;
  logic [31:0]       in_key_second;
  logic [31:0]       in_key_third;
  logic signed [4:0] in_slot_index;
  logic              out_valid;
  logic [3:0]        out_slot_out;
  logic [2:0]        out_status;

  // Table model state and configuration
  logic [15:0]   slot_refs [SLOTS];
  logic [31:0]   slot_key_a [SLOTS];
  logic [31:0]   slot_key_b [SLOTS];
  logic [31:0]   slot_key_c [SLOTS];
  logic [4:0]    entries_reg;
  table_result_t pending_results [$];

  // Key pool for well-formed random traffic
  logic [31:0] pool_a [POOL_SIZE];
  logic [31:0] pool_b [POOL_SIZE];
  logic [31:0] pool_c [POOL_SIZE];

  int mismatches;
  int cycle_count;
  int burst_left;
  int transactions_sent;
  int saturated_hits;
  int status_tally [5];

  refcounted_dedup_table_top #(
    .MAX_ENTRIES(SLOTS),
    .COUNT_BITS (16)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_key_first (in_key_first),
    .in_key_second(in_key_second),
    .in_key_third (in_key_third),
    .in_slot_index(in_slot_index),
    .out_valid    (out_valid),
    .out_slot_out (out_slot_out),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("refcounted_dedup_table_top_tb NOT OK");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what,
               want, got);
  endtask

  // Compare each result strobe against the oldest pending expectation
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, status", -1, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_slot_out !== want.slot)
          note_mismatch("slot_out", want.slot, out_slot_out);
        if (out_status !== want.status)
          note_mismatch("status", want.status, out_status);
      end
    end
  end

  // Table model: apply one transaction, return the result it produces
  function automatic table_result_t predict_table(input logic mode,
                                                  input logic [31:0] ka,
                                                  input logic [31:0] kb,
                                                  input logic [31:0] kc,
                                                  input logic signed [4:0] rel_idx);
    table_result_t res;
    int            n;
    int            slot_no;
    int            free_slot;
    bit            have_free;
    res.slot   = '0;
    res.status = ST_RELEASE;
    have_free  = 1'b0;
    free_slot  = 0;
    n          = (entries_reg > SLOTS) ? SLOTS : entries_reg;
    slot_no    = rel_idx;
    if (mode) begin
      if (slot_no >= 0 && slot_no < n && slot_refs[slot_no] != 0)
        slot_refs[slot_no] = slot_refs[slot_no] - 1'b1;
      return res;
    end
    if (ka == RESERVED_FIRST) begin
      res.status = ST_RESERVED;
      return res;
    end
    for (int i = 0; i < n; i++) begin
      if (slot_refs[i] == 0) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end else if (slot_key_a[i] == ka && slot_key_b[i] == kb && slot_key_c[i] == kc) begin
        if (slot_refs[i] != COUNT_MAX) slot_refs[i] = slot_refs[i] + 1'b1;
        else saturated_hits++;
        res.slot   = 4'(i);
        res.status = ST_MATCHED;
        return res;
      end
    end
    if (!have_free) begin
      res.status = ST_FULL;
      return res;
    end
    slot_refs[free_slot]  = 16'd1;
    slot_key_a[free_slot] = ka;
    slot_key_b[free_slot] = kb;
    slot_key_c[free_slot] = kc;
    res.slot   = 4'(free_slot);
    res.status = ST_ALLOCATED;
    return res;
  endfunction

  // Present one transaction, hold it until accepted, record its expected result
  task automatic send_op(input logic mode, input logic [31:0] ka, input logic [31:0] kb,
                         input logic [31:0] kc, input logic signed [4:0] rel_idx);
    table_result_t res;
    start         <= 1'b1;
    in_mode       <= mode;
    in_key_first  <= ka;
    in_key_second <= kb;
    in_key_third  <= kc;
    in_slot_index <= rel_idx;
    do @(posedge clk); while (busy);
    res = predict_table(mode, ka, kb, kc, rel_idx);
    pending_results.push_back(res);
    status_tally[res.status]++;
    transactions_sent++;
  endtask

  // Bursts of back-to-back transactions separated by random gaps
  task automatic pace_sender;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every pending result has come back and the block is quiet
  task automatic wait_table_idle;
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // Write the table size register, then read it back
  task automatic write_entries(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRIES_ADDR;
    pwdata  <= {27'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    entries_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[4:0] !== value) note_mismatch("entries_in_use readback", value, prdata[4:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reserved_key;
    send_op(1'b0, RESERVED_FIRST, $urandom, $urandom, '0);
    send_op(1'b0, RESERVED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'sd15);
  endtask

  task automatic test_allocate_and_match;
    send_op(1'b0, 32'h0, 32'h0, 32'h0, '0);
    send_op(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_op(1'b0, 32'h0, 32'h0, 32'h0, '0);
    // differ in the last word only
    send_op(1'b0, 32'h0, 32'h0, 32'h1, '0);
    // one bit off the reserved word is an ordinary key
    send_op(1'b0, RESERVED_FIRST ^ 32'h1, 32'h0, 32'h0, '0);
  endtask

  task automatic test_release;
    send_op(1'b1, RESERVED_FIRST, 32'h0, 32'h0, 5'sd0);
    send_op(1'b1, 32'h0, 32'h0, 32'h0, -5'sd2);
    send_op(1'b1, 32'h0, 32'h0, 32'h0, -5'sd1);
    send_op(1'b1, 32'h0, 32'h0, 32'h0, 5'sd10);
    send_op(1'b1, 32'h0, 32'h0, 32'h0, 5'sd15);
    send_op(1'b1, 32'h0, 32'h0, 32'h0, 5'sd5);
    send_op(1'b1, 32'h0, 32'h0, 32'h0, 5'sd2);
    send_op(1'b1, 32'h0, 32'h0, 32'h0, 5'sd2);
  endtask

  task automatic test_table_full;
    wait_table_idle();
    write_entries(5'd2);
    send_op(1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, '0);
    send_op(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
  endtask

  task automatic test_range_register;
    // no active slots: every acquire but a reserved key is full
    wait_table_idle();
    write_entries(5'd0);
    send_op(1'b0, 32'h0, 32'h0, 32'h0, '0);
    send_op(1'b1, 32'h0, 32'h0, 32'h0, 5'sd0);
    send_op(1'b0, RESERVED_FIRST, 32'h0, 32'h0, '0);
    // oversized value behaves as the full table
    wait_table_idle();
    write_entries(5'd31);
    send_op(1'b0, 32'hCAFE_0001, 32'h0, 32'hFFFF_0000, '0);
    // shrink with live slots, then grow back: slot 1 keeps its key
    wait_table_idle();
    write_entries(5'd1);
    send_op(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    wait_table_idle();
    write_entries(5'd16);
    send_op(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
  endtask

  task automatic test_random_traffic;
    int          phase_limit [8] = '{16, 4, 1, 17, 31, 0, 8, 12};
    int          phase_items [8] = '{70, 40, 20, 40, 40, 15, 40, 35};
    int          live [$];
    int          counted;
    int          pick;
    int          n;
    int          tmp;
    logic        mode;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] kc;
    logic signed [4:0] rel_idx;
    for (int i = 0; i < POOL_SIZE; i++) begin
      do pool_a[i] = $urandom; while (pool_a[i] == RESERVED_FIRST);
      pool_b[i] = $urandom;
      pool_c[i] = $urandom;
    end
    pool_a[0] = '0; pool_b[0] = '0; pool_c[0] = '0;
    pool_a[1] = '1; pool_b[1] = '1; pool_c[1] = '1;
    for (int p = 0; p < 8; p++) begin
      wait_table_idle();
      write_entries(5'(phase_limit[p]));
      n       = (phase_limit[p] > SLOTS) ? SLOTS : phase_limit[p];
      counted = 0;
      while (counted < phase_items[p]) begin
        pick    = $urandom_range(0, 99);
        mode    = 1'b0;
        ka      = $urandom;
        kb      = $urandom;
        kc      = $urandom;
        tmp     = $urandom_range(0, 17) - 2;
        rel_idx = tmp[4:0];
        live.delete();
        for (int s = 0; s < n; s++) if (slot_refs[s] != 0) live.push_back(s);
        if (pick < 5) begin
          ka = RESERVED_FIRST;
        end else if (pick < 55) begin
          tmp = $urandom_range(0, POOL_SIZE - 1);
          ka  = pool_a[tmp];
          kb  = pool_b[tmp];
          kc  = pool_c[tmp];
          // near miss: one bit flipped in one word
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
              0: ka ^= 32'd1 << $urandom_range(0, 31);
              1: kb ^= 32'd1 << $urandom_range(0, 31);
              default: kc ^= 32'd1 << $urandom_range(0, 31);
            endcase
          end
        end else if (pick < 90) begin
          mode = 1'b1;
          if (live.size() != 0) rel_idx = 5'(live[$urandom_range(0, live.size() - 1)]);
        end else begin
          mode = 1'b1;
        end
        // ignored releases do not count toward the phase
        tmp = rel_idx;
        if (!mode || (tmp >= 0 && tmp < n && slot_refs[tmp] != 0)) counted++;
        pace_sender();
        send_op(mode, ka, kb, kc, rel_idx);
      end
    end
  endtask

  task automatic test_repeated_acquire;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] kc;
    wait_table_idle();
    write_entries(5'd16);
    // empty the table so the key lands in slot 0
    for (int i = 0; i < SLOTS; i++)
      while (slot_refs[i] != 0) send_op(1'b1, '0, '0, '0, 5'(i));
    do ka = $urandom; while (ka == RESERVED_FIRST);
    kb = $urandom;
    kc = $urandom;
    repeat (REPEAT_ACQUIRES) send_op(1'b0, ka, kb, kc, '0);
    send_op(1'b1, '0, '0, '0, 5'sd0);
    send_op(1'b0, ka, kb, kc, '0);
    send_op(1'b0, ka, kb, kc, '0);
  endtask

  initial begin
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    start         <= 1'b0;
    in_mode       <= 1'b0;
    in_key_first  <= '0;
    in_key_second <= '0;
    in_key_third  <= '0;
    in_slot_index <= '0;
    cycle_count       = 0;
    mismatches        = 0;
    burst_left        = 0;
    transactions_sent = 0;
    saturated_hits    = 0;
    entries_reg       = ENTRIES_RESET;
    foreach (status_tally[i]) status_tally[i] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_refs[i]  = '0;
      slot_key_a[i] = '0;
      slot_key_b[i] = '0;
      slot_key_c[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reserved_key();
    test_allocate_and_match();
    test_release();
    test_table_full();
    test_range_register();
    test_random_traffic();
    test_repeated_acquire();

    wait_table_idle();
    $display("ran %0d transactions over table sizes 0 to 31: %0d matched, %0d allocated,",
             transactions_sent, status_tally[ST_MATCHED], status_tally[ST_ALLOCATED]);
    $display("%0d full, %0d reserved, %0d releases, %0d matches at count limit",
             status_tally[ST_FULL], status_tally[ST_RESERVED], status_tally[ST_RELEASE],
             saturated_hits);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("refcounted_dedup_table_top_tb OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_results.size());
      $display("refcounted_dedup_table_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== refcounted_dedup_table_top.f =====
src/rcdt_pkg.sv
src/rcdt_ram.sv
src/rcdt_ctrl.sv
src/rcdt_dp.sv
src/refcounted_dedup_table_top.sv
bench/refcounted_dedup_table_top_tb.sv
